@@ design/ife_pkg.sv @@
// shared constants, types and the arctangent table of the instantaneous frequency estimator
package ife_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    localparam int CORDIC_W = SAMPLE_WIDTH + 3;
    localparam int ACC_W    = 24;
    localparam int STEP_W   = $clog2(CORDIC_STEPS);
    localparam int PHASE_W  = 16;
    localparam int RATE_W   = 24;
    localparam int FREQ_W   = 32;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = PHASE_W + RATE_W + 1;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [ACC_W-1:0]  ACC_QUARTER = ACC_W'(4194304);
    localparam logic [ACC_W-1:0]  ACC_ROUND   = ACC_W'(128);
    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(48000);

    // register index decoded from paddr[2]
    localparam logic REG_SAMPLE_RATE = 1'b0;

    typedef struct packed {
        logic load;
        logic step;
    } t_cordic_ctl;

    function automatic logic [ACC_W-1:0] atan_angle(input logic [STEP_W-1:0] idx);
        logic [ACC_W-1:0] a;
        case (int'(idx))
            0:       a = ACC_W'(2097152);
            1:       a = ACC_W'(1238021);
            2:       a = ACC_W'(654136);
            3:       a = ACC_W'(332050);
            4:       a = ACC_W'(166669);
            5:       a = ACC_W'(83416);
            6:       a = ACC_W'(41718);
            7:       a = ACC_W'(20860);
            8:       a = ACC_W'(10430);
            9:       a = ACC_W'(5215);
            10:      a = ACC_W'(2608);
            11:      a = ACC_W'(1304);
            12:      a = ACC_W'(652);
            13:      a = ACC_W'(326);
            14:      a = ACC_W'(163);
            15:      a = ACC_W'(81);
            16:      a = ACC_W'(41);
            17:      a = ACC_W'(20);
            18:      a = ACC_W'(10);
            19:      a = ACC_W'(5);
            20:      a = ACC_W'(3);
            21:      a = ACC_W'(1);
            22:      a = ACC_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ design/ife_cordic.sv @@
// vectoring cordic, one micro-rotation per cycle, giving a 16-bit binary angle
module ife_cordic (
    input  logic                                i_clk,
    input  ife_pkg::t_cordic_ctl                i_ctl,
    input  logic signed [ife_pkg::SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [ife_pkg::SAMPLE_WIDTH-1:0] i_y,
    output logic [ife_pkg::PHASE_W-1:0]         o_phase,
    output logic                                o_last
);
    import ife_pkg::*;

    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic [ACC_W-1:0]           r_acc;
    logic [STEP_W-1:0]          r_step;
    logic                       r_zero;

    logic signed [CORDIC_W-1:0] w_xe;
    logic signed [CORDIC_W-1:0] w_ye;
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic [ACC_W-1:0]           w_rnd;

    assign w_xe = CORDIC_W'(i_x);
    assign w_ye = CORDIC_W'(i_y);
    assign w_dx = r_y >>> r_step;
    assign w_dy = r_x >>> r_step;
    assign w_rnd = r_acc + ACC_ROUND;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_step <= '0;
            r_zero <= (i_x == '0) && (i_y == '0);
            // left half plane: quarter turn into the right half first
            if (w_xe < 0) begin
                if (w_ye >= 0) begin
                    r_x   <= w_ye;
                    r_y   <= -w_xe;
                    r_acc <= ACC_QUARTER;
                end else begin
                    r_x   <= -w_ye;
                    r_y   <= w_xe;
                    r_acc <= -ACC_QUARTER;
                end
            end else begin
                r_x   <= w_xe;
                r_y   <= w_ye;
                r_acc <= '0;
            end
        end else if (i_ctl.step) begin
            r_step <= r_step + STEP_W'(1);
            if (r_y > 0) begin
                r_x   <= r_x + w_dx;
                r_y   <= r_y - w_dy;
                r_acc <= r_acc + atan_angle(r_step);
            end else begin
                r_x   <= r_x - w_dx;
                r_y   <= r_y + w_dy;
                r_acc <= r_acc - atan_angle(r_step);
            end
        end
    end

    assign o_last  = (r_step == STEP_W'(CORDIC_STEPS - 1));
    assign o_phase = r_zero ? '0 : w_rnd[ACC_W-1 -: PHASE_W];

endmodule

@@ design/instantaneous_frequency_estimator_core.sv @@
// top level of the instantaneous frequency estimator: sequencer, phase difference and scaling
// Each transfer on the input channel is one complex sample; its phase is found by a
// vectoring cordic that runs one micro-rotation per cycle on a single shared
// add/shift unit, so a sample occupies the block while it takes the transfer, runs
// CORDIC_STEPS = 16 iterations, forms the phase difference and does the scaling
// multiply; a sample that produces no result skips the multiply.
// The first sample of a block (or the first after reset) only stores its phase.
// Every other sample gives floor(wrapped_phase_change * sample_rate_hz / 256)
// as a 32-bit signed frequency with 8 fraction bits. The result sits in an output
// register, so the next sample is taken while it waits to be transferred; the
// scaling step holds only if a previous result is still waiting. sample_rate_hz
// lives at apb byte address 0 and should be written while the block is idle.
module instantaneous_frequency_estimator_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // sample input channel
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [ife_pkg::SAMPLE_WIDTH-1:0] i_sample_real,
    input  logic signed [ife_pkg::SAMPLE_WIDTH-1:0] i_sample_imag,
    input  logic                                    i_start_of_block,
    // frequency output channel
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [ife_pkg::FREQ_W-1:0]       o_frequency_q8,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ife_pkg::PADDR_W-1:0]             paddr,
    input  logic [ife_pkg::DATA_W-1:0]              pwdata,
    output logic [ife_pkg::DATA_W-1:0]              prdata,
    output logic                                    pready
);
    import ife_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ITER  = 4'b0010,
        S_DIFF  = 4'b0100,
        S_SCALE = 4'b1000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [RATE_W-1:0]        r_rate;
    logic [PHASE_W-1:0]       r_prev;
    logic                     r_have;
    logic                     r_start;
    logic [PHASE_W-1:0]       r_change;
    logic                     r_out_valid;
    logic signed [FREQ_W-1:0] r_out_data;

    t_cordic_ctl              w_ctl;
    logic [PHASE_W-1:0]       w_phase;
    logic                     w_last;
    logic                     w_in_xfer;
    logic                     w_out_xfer;
    logic                     w_out_free;
    logic                     w_cfg_wr;
    logic signed [PROD_W-1:0] w_prod;

    assign w_in_xfer  = i_valid && (r_state == S_IDLE);
    assign w_out_xfer = r_out_valid && !i_stall;
    // output register can take a new result this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_RATE);

    assign w_ctl.load = w_in_xfer;
    assign w_ctl.step = (r_state == S_ITER);

    ife_cordic u_cordic (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_x     (i_sample_real),
        .i_y     (i_sample_imag),
        .o_phase (w_phase),
        .o_last  (w_last)
    );

    // signed change times unsigned rate, floor shift by the fraction bits
    assign w_prod = PROD_W'($signed(r_change)) * PROD_W'($signed({1'b0, r_rate}));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_ITER;
            end
            S_ITER: begin
                if (w_last) n_state = S_DIFF;
            end
            S_DIFF: begin
                n_state = (r_start || !r_have) ? S_IDLE : S_SCALE;
            end
            S_SCALE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) r_rate <= pwdata[RATE_W-1:0];
            if (r_state == S_DIFF) begin
                r_prev <= w_phase;
                r_have <= 1'b1;
            end
            if ((r_state == S_SCALE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) r_start <= i_start_of_block;
        // modular subtraction wraps the change into [-pi, pi)
        if (r_state == S_DIFF) r_change <= w_phase - r_prev;
        if ((r_state == S_SCALE) && w_out_free) begin
            r_out_data <= w_prod[FRAC_W +: FREQ_W];
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_frequency_q8 = r_out_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? DATA_W'(r_rate) : '0;

endmodule

@@ design/ife_checker.sv @@
// port-level checks for the instantaneous frequency estimator, bound to the top level
module ife_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_valid,
    input logic                                    o_stall,
    input logic                                    o_valid,
    input logic                                    i_stall,
    input logic signed [ife_pkg::FREQ_W-1:0]       o_frequency_q8,
    input logic                                    psel,
    input logic                                    pready
);
    import ife_pkg::*;

    // a waiting result holds its value until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frequency_q8))
        else $error("result changed while stalled");

    // a taken sample still has the block busy once all cordic iterations are done
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ##(CORDIC_STEPS) o_stall)
        else $error("sample input freed before cordic finished");

    // reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // configuration port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind instantaneous_frequency_estimator_core ife_checker u_ife_checker (.*);
